// ----- src/slr_pkg.sv -----
// Shared constants and types of the stereo linear resampler.
package slr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 18;
  localparam int PHASE_W    = 19;
  localparam int CALC_W     = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = DIFF_W + FRAC_BITS + 1;
  localparam int NUM_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RATIO_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 1'd1;

  localparam logic [STEP_W-1:0] RATIO_RESET = STEP_W'(44739);

  // Control of one interpolation travelling beside the lane data.
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

endpackage

// ----- src/stereo_linear_resampler_unit.sv -----
// Top level of the stereo linear resampler: frame sequencer, two lanes and output merge.
//
// Each accepted source frame (tdata: left in bits 15:0, right in 31:16) yields zero to
// eight output frames at fractional positions between the held frame and the new one;
// tlast marks the final output of a frame. The sequencer issues one interpolation per
// cycle unless the output stalls; in_tready stays low while a frame's outputs issue, and
// the next frame is taken in the cycle after its last issue; a frame that produces no
// output (the first frame after reset, or one that downsampling steps over) is absorbed
// in its accept cycle and in_tready stays high. Output stalls hold the whole pipe. Each
// output passes one registered multiply per lane and then the merge register.
// Bypass returns every frame unchanged with tlast set. Config registers:
// index 0 ratio_step (18 bits, 16 fraction bits, values below one eighth act as one
// eighth), index 1 bypass; write them only while the block is idle.
module stereo_linear_resampler_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // left_in, right_in
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // left_out, right_out
  output logic                            out_tlast,  // last_of_run
  input  logic                            cfg_we,
  input  logic [slr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slr_pkg::STEP_W-1:0]      cfg_wdata
);

  localparam logic [slr_pkg::CALC_W-1:0] ONE_Q    = slr_pkg::CALC_W'(1) << slr_pkg::FRAC_BITS;
  localparam logic [slr_pkg::CALC_W-1:0] MIN_STEP = ONE_Q >> 3;

  // Configuration.
  logic [slr_pkg::STEP_W-1:0] ratio_step_r;
  logic                       bypass_r;

  // Frame state.
  logic signed [slr_pkg::SAMPLE_W-1:0] held_l_r, held_r_r;
  logic signed [slr_pkg::SAMPLE_W-1:0] cur_l_r, cur_r_r;
  logic [slr_pkg::PHASE_W-1:0]         phase_r, phase_nxt;
  logic                                primed_r, primed_nxt;
  logic                                busy_r, busy_nxt;
  logic                                load_held;

  // Issue stage.
  slr_pkg::pipe_ctl_t            ctl_r, ctl_nxt;
  logic                          en;
  logic                          in_fire;
  logic                          issue;
  logic [slr_pkg::CALC_W-1:0]    step_cfg;
  logic [slr_pkg::CALC_W-1:0]    step_eff;
  logic [slr_pkg::CALC_W-1:0]    phase_ext;
  logic [slr_pkg::CALC_W-1:0]    phase_adv;
  logic                          adv_last;
  logic signed [slr_pkg::SAMPLE_W-1:0] lane_held_l, lane_held_r;
  logic [slr_pkg::FRAC_BITS-1:0] lane_ph;
  logic signed [slr_pkg::SAMPLE_W-1:0] left_res, right_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_step_r <= slr_pkg::RATIO_RESET;
      bypass_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        slr_pkg::REG_RATIO_STEP: ratio_step_r <= cfg_wdata;
        slr_pkg::REG_BYPASS:     bypass_r     <= cfg_wdata[0];
        default:                 ;
      endcase
    end
  end

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign issue     = busy_r && en;

  assign step_cfg  = slr_pkg::CALC_W'(ratio_step_r);
  assign step_eff  = (step_cfg < MIN_STEP) ? MIN_STEP : step_cfg;
  assign phase_ext = slr_pkg::CALC_W'(phase_r);
  assign phase_adv = phase_ext + step_eff;
  assign adv_last  = (phase_adv >= ONE_Q);

  // Bypass feeds the lanes the new frame at phase zero, which returns it unchanged.
  assign lane_held_l = bypass_r ? cur_l_r : held_l_r;
  assign lane_held_r = bypass_r ? cur_r_r : held_r_r;
  assign lane_ph     = bypass_r ? '0 : phase_r[slr_pkg::FRAC_BITS-1:0];

  always_comb begin
    phase_nxt     = phase_r;
    primed_nxt    = primed_r;
    busy_nxt      = busy_r;
    load_held     = 1'b0;
    ctl_nxt.valid = issue;
    ctl_nxt.last  = 1'b0;
    if (in_fire) begin
      if (bypass_r) begin
        busy_nxt = 1'b1;
      end else if (!primed_r) begin
        // First frame: hold it, no output.
        primed_nxt = 1'b1;
        load_held  = 1'b1;
      end else if (phase_ext >= ONE_Q) begin
        // Frame stepped over: hold it, drop one from the phase.
        phase_nxt = slr_pkg::PHASE_W'(phase_ext - ONE_Q);
        load_held = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (issue) begin
      if (bypass_r) begin
        ctl_nxt.last = 1'b1;
        primed_nxt   = 1'b1;
        load_held    = 1'b1;
        busy_nxt     = 1'b0;
      end else begin
        ctl_nxt.last = adv_last;
        if (adv_last) begin
          phase_nxt = slr_pkg::PHASE_W'(phase_adv - ONE_Q);
          load_held = 1'b1;
          busy_nxt  = 1'b0;
        end else begin
          phase_nxt = slr_pkg::PHASE_W'(phase_adv);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_l_r <= '0;
      held_r_r <= '0;
      phase_r  <= '0;
      primed_r <= 1'b0;
      busy_r   <= 1'b0;
      ctl_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      primed_r <= primed_nxt;
      busy_r   <= busy_nxt;
      if (en) begin
        ctl_r <= ctl_nxt;
      end
      if (load_held) begin
        // A frame absorbed at accept comes from the port, otherwise from the current frame.
        held_l_r <= in_fire ? signed'(in_tdata[15:0])  : cur_l_r;
        held_r_r <= in_fire ? signed'(in_tdata[31:16]) : cur_r_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_l_r <= signed'(in_tdata[15:0]);
      cur_r_r <= signed'(in_tdata[31:16]);
    end
  end

  slr_lane u_lane_left (
    .clk    (clk),
    .en     (en),
    .held   (lane_held_l),
    .cur    (cur_l_r),
    .ph     (lane_ph),
    .result (left_res)
  );

  slr_lane u_lane_right (
    .clk    (clk),
    .en     (en),
    .held   (lane_held_r),
    .cur    (cur_r_r),
    .ph     (lane_ph),
    .result (right_res)
  );

  slr_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_r),
    .left_res   (left_res),
    .right_res  (right_res),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/slr_lane.sv -----
// One channel lane: registered (cur - held) * phase, then add and truncate toward zero.
module slr_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]  held,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]  cur,
  input  logic        [slr_pkg::FRAC_BITS-1:0] ph,
  output logic signed [slr_pkg::SAMPLE_W-1:0]  result
);

  logic signed [slr_pkg::DIFF_W-1:0]  diff;
  logic signed [slr_pkg::FRAC_BITS:0] ph_s;
  logic signed [slr_pkg::PROD_W-1:0]  prod_r;
  logic signed [slr_pkg::SAMPLE_W-1:0] held_r;
  logic signed [slr_pkg::NUM_W-1:0]   num;
  logic signed [slr_pkg::NUM_W-slr_pkg::FRAC_BITS-1:0] quo;

  assign diff = {cur[slr_pkg::SAMPLE_W-1], cur} - {held[slr_pkg::SAMPLE_W-1], held};
  assign ph_s = {1'b0, ph};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= slr_pkg::PROD_W'(diff) * slr_pkg::PROD_W'(ph_s);
      held_r <= held;
    end
  end

  assign num = {{(slr_pkg::NUM_W - slr_pkg::SAMPLE_W - slr_pkg::FRAC_BITS){held_r[slr_pkg::SAMPLE_W-1]}},
                held_r, {slr_pkg::FRAC_BITS{1'b0}}}
             + {prod_r[slr_pkg::PROD_W-1], prod_r};

  // Floor shift, then step up by one for negative values with a remainder.
  always_comb begin
    quo = num[slr_pkg::NUM_W-1:slr_pkg::FRAC_BITS];
    if (num[slr_pkg::NUM_W-1] && (|num[slr_pkg::FRAC_BITS-1:0])) begin
      quo = quo + (slr_pkg::NUM_W - slr_pkg::FRAC_BITS)'(1);
    end
  end

  assign result = quo[slr_pkg::SAMPLE_W-1:0];

endmodule

// ----- src/slr_merge.sv -----
// Output register that joins both lane results into one result transfer.
module slr_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slr_pkg::pipe_ctl_t                  ctl,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] left_res,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] right_res,
  output logic                                en,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // left_out, right_out
  output logic                                out_tlast   // last_of_run
);

  logic                         valid_r;
  logic                         last_r;
  logic [slr_pkg::SAMPLE_W-1:0] left_r;
  logic [slr_pkg::SAMPLE_W-1:0] right_r;

  // Advance the whole pipe unless a result waits here.
  assign en = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r  <= ctl.last;
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {right_r, left_r};
  assign out_tlast  = last_r;

endmodule
